@@ design/neighbor_mean_filter_3x3_defines.svh @@
// Assertion macros used by the checker file of the neighbor mean filter.
`ifndef NEIGHBOR_MEAN_FILTER_3X3_DEFINES_SVH
`define NEIGHBOR_MEAN_FILTER_3X3_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define NMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define NMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nmf_pkg.sv @@
// Shared types and constants of the neighbor mean filter.
package nmf_pkg;

  localparam int PIX_W  = 16;
  localparam int OUT_W  = 16;
  localparam int ROW_W  = 10;
  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

  // Divisor picked by how many image edges touch the pixel
  typedef enum logic [1:0] {
    DIV_BY_8 = 2'd0,
    DIV_BY_5 = 2'd1,
    DIV_BY_3 = 2'd2
  } div_code_t;

  // Result slots of one request, in delivery order
  typedef enum logic [1:0] {
    SLOT_UP_LEFT   = 2'd0,
    SLOT_UP_RIGHT  = 2'd1,
    SLOT_LOW_LEFT  = 2'd2,
    SLOT_LOW_RIGHT = 2'd3
  } res_slot_t;

  typedef struct packed {
    logic      accept;
    logic      shift;
    logic      sum;
    logic      mult;
    logic      load;
    res_slot_t slot;
    logic      last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [3:0] res_flags;
    logic       out_free;
  } dp_status_t;

endpackage

@@ design/nmf_stream_if.sv @@
// Valid/ready channel interfaces for pixel requests and filter results.
interface nmf_pix_if import nmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface nmf_res_if import nmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] mean_value;
  logic [ROW_W-1:0] out_row;
  logic [ROW_W-1:0] out_column;
  logic             run_last;
  logic             frame_done;

  modport source (output valid, output mean_value, output out_row, output out_column,
                  output run_last, output frame_done, input ready);
  modport sink (input valid, input mean_value, input out_row, input out_column,
                input run_last, input frame_done, output ready);
endinterface

@@ design/nmf_ctrl.sv @@
// Controller: sequences one pixel request through read, shift and per-result steps.
module nmf_ctrl import nmf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_MULT,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic [3:0] pend_r;
  res_slot_t  slot_r;
  logic [3:0] slot_bit;

  function automatic res_slot_t first_slot(input logic [3:0] m);
    res_slot_t s;
    if (m[0]) begin
      s = SLOT_UP_LEFT;
    end else if (m[1]) begin
      s = SLOT_UP_RIGHT;
    end else if (m[2]) begin
      s = SLOT_LOW_LEFT;
    end else begin
      s = SLOT_LOW_RIGHT;
    end
    return s;
  endfunction

  assign slot_bit = 4'b0001 << slot_r;
  assign in_ready = (state_r == S_IDLE);

  // Decode commands from state
  always_comb begin
    cmd        = '0;
    cmd.slot   = slot_r;
    cmd.last   = ((pend_r & ~slot_bit) == 4'b0000);
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.shift  = (state_r == S_SHIFT);
    cmd.sum    = (state_r == S_SUM);
    cmd.mult   = (state_r == S_MULT);
    cmd.load   = (state_r == S_EMIT) && status.out_free;
  end

  // Hold state, pending results and the current slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 4'b0000;
      slot_r  <= SLOT_UP_LEFT;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pend_r <= status.res_flags;
          slot_r <= first_slot(status.res_flags);
          if (status.res_flags != 4'b0000) begin
            state_r <= S_SUM;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SUM: begin
          pend_r  <= pend_r & ~slot_bit;
          state_r <= S_MULT;
        end
        S_MULT: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (status.out_free) begin
            slot_r <= first_slot(pend_r);
            if (pend_r != 4'b0000) begin
              state_r <= S_SUM;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/nmf_datapath.sv @@
// Datapath: line store, 3x3 window, masked neighbor sum, divider and output register.
module nmf_datapath import nmf_pkg::*; #(
  parameter int MAX_SIZE   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_mean,
  output logic [ROW_W-1:0]  out_row,
  output logic [ROW_W-1:0]  out_col,
  output logic              out_last,
  output logic              out_done,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status
);

  localparam int AW = $clog2(MAX_SIZE);
  localparam int PW = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int SW = PW + 3;
  localparam int K  = SW + 2;
  localparam int MW = K - 1;
  localparam int PRW = SW + MW;
  localparam logic [MW-1:0] M5_C = MW'(((64'd1 << K) + 64'd4) / 64'd5);
  localparam logic [MW-1:0] M3_C = MW'(((64'd1 << K) + 64'd2) / 64'd3);

  function automatic logic [AW-1:0] size_to_last(input logic [SIZE_W-1:0] s);
    logic [AW-1:0] v;
    if (s < 2) begin
      v = AW'(1);
    end else if (s > MAX_SIZE) begin
      v = AW'(MAX_SIZE - 1);
    end else begin
      v = AW'(s - 1'b1);
    end
    return v;
  endfunction

  // Two previous rows share one memory word per column: {upper, middle}
  logic [2*PW-1:0] line_mem [MAX_SIZE];

  logic [AW-1:0]   last_idx_r;
  logic [AW-1:0]   row_r, col_r;
  logic [AW-1:0]   cur_row_r, cur_col_r;
  logic [PW-1:0]   pix_r, rd_up_r, rd_mid_r;
  logic [PW-1:0]   win_r [3][3];
  logic [SW-1:0]   sum_r, sum_nxt;
  div_code_t       div_r, div_nxt;
  logic [AW-1:0]   res_row_r, res_col_r, res_row_nxt, res_col_nxt;
  logic            res_last_r, res_done_r;
  logic [PRW-1:0]  prod_r;
  logic [MW-1:0]   mult_c;
  logic [PW-1:0]   mean_c;
  logic            out_valid_r, out_last_r, out_done_r;
  logic [OUT_W-1:0] out_mean_r;
  logic [ROW_W-1:0] out_row_r, out_col_r;
  logic            sel_row, sel_col, top, bot, lft, rgt;

  // Results made by the pixel at the current position
  always_comb begin
    status.res_flags[0] = (row_r != '0) && (col_r != '0);
    status.res_flags[1] = (row_r != '0) && (col_r == last_idx_r);
    status.res_flags[2] = (row_r == last_idx_r) && (col_r != '0);
    status.res_flags[3] = (row_r == last_idx_r) && (col_r == last_idx_r);
    status.out_free     = !out_valid_r || out_ready;
  end

  // Hold size and position; a size write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= size_to_last(SIZE_RESET);
      row_r      <= '0;
      col_r      <= '0;
    end else if (cfg_wr_en) begin
      last_idx_r <= size_to_last(cfg_wr_data);
      row_r      <= '0;
      col_r      <= '0;
    end else if (cmd.shift) begin
      if (col_r == last_idx_r) begin
        col_r <= '0;
        row_r <= (row_r == last_idx_r) ? '0 : AW'(row_r + 1'b1);
      end else begin
        col_r <= AW'(col_r + 1'b1);
      end
    end
  end

  // Read the line store on a request, write back and shift the window next cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      {rd_up_r, rd_mid_r} <= line_mem[col_r];
      pix_r               <= in_pixel[PW-1:0];
    end
    if (cmd.shift) begin
      line_mem[col_r] <= {rd_mid_r, pix_r};
      cur_row_r       <= row_r;
      cur_col_r       <= col_r;
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_up_r;
      win_r[1][2] <= rd_mid_r;
      win_r[2][2] <= pix_r;
    end
  end

  // Masked sum of the in-image neighbors for the selected slot
  always_comb begin
    logic [1:0] rr;
    logic [1:0] cc;
    logic       keep;
    sel_row     = cmd.slot[1];
    sel_col     = cmd.slot[0];
    res_row_nxt = sel_row ? last_idx_r : AW'(cur_row_r - 1'b1);
    res_col_nxt = sel_col ? last_idx_r : AW'(cur_col_r - 1'b1);
    top = (res_row_nxt == '0);
    bot = (res_row_nxt == last_idx_r);
    lft = (res_col_nxt == '0);
    rgt = (res_col_nxt == last_idx_r);
    sum_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        rr   = 2'(a) + 2'(sel_row);
        cc   = 2'(b) + 2'(sel_col);
        keep = !(a == 1 && b == 1) && !(a == 0 && top) && !(a == 2 && bot) &&
               !(b == 0 && lft) && !(b == 2 && rgt);
        if (keep && rr < 2'd3 && cc < 2'd3) begin
          sum_nxt = SW'(sum_nxt + SW'(win_r[rr][cc]));
        end
      end
    end
    case ({top | bot, lft | rgt})
      2'b00:   div_nxt = DIV_BY_8;
      2'b11:   div_nxt = DIV_BY_3;
      default: div_nxt = DIV_BY_5;
    endcase
  end

  // Register the sum, then the reciprocal product
  assign mult_c = (div_r == DIV_BY_5) ? M5_C : M3_C;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r      <= sum_nxt;
      div_r      <= div_nxt;
      res_row_r  <= res_row_nxt;
      res_col_r  <= res_col_nxt;
      res_last_r <= cmd.last;
      res_done_r <= (cmd.slot == SLOT_LOW_RIGHT);
    end
    if (cmd.mult) begin
      prod_r <= PRW'(sum_r) * PRW'(mult_c);
    end
  end

  // Pick the quotient
  always_comb begin
    case (div_r)
      DIV_BY_8: mean_c = PW'(sum_r >> 3);
      default:  mean_c = PW'(prod_r >> K);
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_mean_r <= OUT_W'(mean_c);
      out_row_r  <= ROW_W'(res_row_r);
      out_col_r  <= ROW_W'(res_col_r);
      out_last_r <= res_last_r;
      out_done_r <= res_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule

@@ design/neighbor_mean_filter_3x3.sv @@
// Top level of the 3x3 neighbor mean filter (center pixel excluded).
// Pixels of a square image enter in raster order; each result is the truncated
// mean of a pixel's in-image neighbors (corners divide by 3, edges by 5, the
// interior by 8) and carries its row and column, run_last on the last result of
// a request and frame_done on the bottom-right pixel. The controller steps each
// result a request makes in turn through one shared sum, multiply and output
// stage, and a stalled result channel holds back a pending result. A new
// request is taken as soon as the last result sits in the output register.
// Writing image_size (clamped to 2..MAX_SIZE) restarts the frame at row 0,
// column 0; the line store needs no clearing after reset.
module neighbor_mean_filter_3x3 import nmf_pkg::*; #(
  parameter int MAX_SIZE   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  nmf_pix_if.sink           in_chan,
  nmf_res_if.source         out_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  nmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nmf_datapath #(
    .MAX_SIZE   (MAX_SIZE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_pixel    (in_chan.pixel_value),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_mean    (out_chan.mean_value),
    .out_row     (out_chan.out_row),
    .out_col     (out_chan.out_column),
    .out_last    (out_chan.run_last),
    .out_done    (out_chan.frame_done),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

@@ design/nmf_checker.sv @@
// Port-level checker for the neighbor mean filter, bound to the top level.
`include "neighbor_mean_filter_3x3_defines.svh"

module nmf_checker import nmf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_mean_value,
  input logic [ROW_W-1:0] out_row,
  input logic [ROW_W-1:0] out_column,
  input logic             out_run_last,
  input logic             out_frame_done
);

  // A stalled result holds
  `NMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mean_value) && $stable(out_row) && $stable(out_column) && $stable(out_run_last) && $stable(out_frame_done), "stalled result changed")

  // The frame's final result ends its request
  `NMF_ASSERT_SAME(a_done_last, out_valid && out_frame_done, out_run_last, "frame_done without run_last")

  // The frame's final result has equal row and column, as the bottom-right corner does
  `NMF_ASSERT_SAME(a_done_corner, out_valid && out_frame_done, out_row == out_column, "frame_done off the corner")

  // One request at a time
  `NMF_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "ready right after a request")

endmodule

bind neighbor_mean_filter_3x3 nmf_checker u_nmf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_mean_value (out_chan.mean_value),
  .out_row        (out_chan.out_row),
  .out_column     (out_chan.out_column),
  .out_run_last   (out_chan.run_last),
  .out_frame_done (out_chan.frame_done)
);
